// ===== sv/wstd_pkg.sv =====
// ----------------------------------------------------------------------------
// wstd_pkg: weighted server task dispatcher shared types
// Word layouts, command codes and time constants.
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int TIME_W   = 32;
  localparam int WEIGHT_W = 18;
  localparam int SLOT_W   = 6;
  localparam int DUR_W    = 18;
  localparam int CFG_W    = 7;

  localparam logic              CMD_LOAD  = 1'b0;
  localparam logic              CMD_TASK  = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;

  typedef struct packed {
    logic                cmd;
    logic [SLOT_W-1:0]   server_slot;
    logic [WEIGHT_W-1:0] weight;
    logic [DUR_W-1:0]    duration;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] server_index;
    logic [TIME_W-1:0] start_time;
  } out_word_t;

endpackage

// ===== sv/wstd_ram.sv =====
// ----------------------------------------------------------------------------
// wstd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wstd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/weighted_server_task_dispatcher_top.sv =====
// Load word: no result, and the next word is accepted the cycle after.
// Task word: the input stalls while a single read pass over the busy and weight
// memories runs at one entry per cycle over n = servers in use (clamped to
// 1..MAX_SERVERS) entries, and until the result word is registered.
// Reset (synchronous): a clearing pass over all MAX_SERVERS entries zeroes the
// busy memory; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// weighted_server_task_dispatcher_top: least-weight free server dispatcher
// Keeps server weights and release times in RAM and assigns each task to the
// lightest free server, moving the start time forward when none is free.
// ----------------------------------------------------------------------------
module weighted_server_task_dispatcher_top #(
  parameter int MAX_SERVERS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wstd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  wstd_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output wstd_pkg::out_word_t           out_data
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int TW    = wstd_pkg::TIME_W;
  localparam int WW    = wstd_pkg::WEIGHT_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_PICK  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [wstd_pkg::CFG_W-1:0] servers_in_use;
  logic [CNT_W-1:0]           n_eff;
  logic [TW-1:0]              task_count;
  logic [TW-1:0]              last_start;
  logic [TW-1:0]              start0;
  logic [wstd_pkg::DUR_W-1:0] duration;
  logic [CNT_W-1:0]           issue_idx;
  logic                       pend;
  logic [IDX_W-1:0]           pend_idx;
  logic [IDX_W-1:0]           clear_idx;
  logic                       have_free;
  logic [WW-1:0]              free_w;
  logic [IDX_W-1:0]           free_idx;
  logic                       have_min;
  logic [TW-1:0]              min_busy;
  logic [WW-1:0]              min_w;
  logic [IDX_W-1:0]           min_idx;
  logic [TW-1:0]              rd_busy;
  logic [WW-1:0]              rd_weight;
  logic                       busy_we;
  logic [IDX_W-1:0]           busy_waddr;
  logic [TW-1:0]              busy_wdata;
  logic                       wt_we;
  logic [IDX_W-1:0]           rd_addr;
  logic [TW-1:0]              pick_start;
  logic [IDX_W-1:0]           pick_idx;
  logic [TW:0]                finish_sum;
  logic [TW-1:0]              finish_time;
  logic                       accept;
  logic                       accept_task;
  logic                       scan_done;
  logic                       out_free;
  logic                       finish;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign accept_task = accept && (in_data.cmd == wstd_pkg::CMD_TASK);
  assign out_free    = !out_valid || !out_stall;
  assign scan_done   = (issue_idx == n_eff);
  assign finish      = (state == ST_PICK) && out_free;

  always_comb begin
    if (servers_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if ({25'd0, servers_in_use} > 32'(MAX_SERVERS)) begin
      n_eff = CNT_W'(MAX_SERVERS);
    end else begin
      n_eff = CNT_W'(servers_in_use);
    end
  end

  assign pick_start  = have_free ? start0 : min_busy;
  assign pick_idx    = have_free ? free_idx : min_idx;
  assign finish_sum  = {1'b0, pick_start} + {{(TW + 1 - wstd_pkg::DUR_W){1'b0}}, duration};
  assign finish_time = finish_sum[TW] ? wstd_pkg::TIME_MAX : finish_sum[TW-1:0];

  assign rd_addr    = issue_idx[IDX_W-1:0];
  assign busy_we    = (state == ST_CLEAR) || finish;
  assign busy_waddr = (state == ST_CLEAR) ? clear_idx : pick_idx;
  assign busy_wdata = (state == ST_CLEAR) ? '0 : finish_time;
  assign wt_we      = accept && (in_data.cmd == wstd_pkg::CMD_LOAD) &&
                      ({26'd0, in_data.server_slot} < 32'(MAX_SERVERS));

  wstd_ram #(.WIDTH(TW), .DEPTH(MAX_SERVERS)) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (rd_addr),
    .rdata (rd_busy)
  );

  wstd_ram #(.WIDTH(WW), .DEPTH(MAX_SERVERS)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (IDX_W'(in_data.server_slot)),
    .wdata (in_data.weight),
    .raddr (rd_addr),
    .rdata (rd_weight)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_idx == IDX_W'(MAX_SERVERS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_task) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clear_idx      <= '0;
      servers_in_use <= wstd_pkg::CFG_RESET;
      task_count     <= '0;
      last_start     <= '0;
      out_valid      <= 1'b0;
      pend           <= 1'b0;
      issue_idx      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        servers_in_use <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + 1'b1;
      end
      if (accept_task) begin
        if (task_count != wstd_pkg::TIME_MAX) begin
          task_count <= task_count + 1'b1;
        end
        issue_idx <= '0;
        pend      <= 1'b0;
      end
      if (state == ST_SCAN) begin
        if (!scan_done) begin
          issue_idx <= issue_idx + 1'b1;
          pend      <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (finish) begin
        last_start <= pick_start;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_task) begin
      start0    <= (last_start > task_count) ? last_start : task_count;
      duration  <= in_data.duration;
      have_free <= 1'b0;
      have_min  <= 1'b0;
    end
    if (state == ST_SCAN) begin
      pend_idx <= rd_addr;
    end
    if (pend) begin
      if ((rd_busy <= start0) && (!have_free || (rd_weight < free_w))) begin
        have_free <= 1'b1;
        free_w    <= rd_weight;
        free_idx  <= pend_idx;
      end
      if (!have_min || (rd_busy < min_busy) ||
          ((rd_busy == min_busy) && (rd_weight < min_w))) begin
        have_min <= 1'b1;
        min_busy <= rd_busy;
        min_w    <= rd_weight;
        min_idx  <= pend_idx;
      end
    end
    if (finish) begin
      out_data.server_index <= wstd_pkg::SLOT_W'(pick_idx);
      out_data.start_time   <= pick_start;
    end
  end

endmodule

// ===== sv/wstd_chk.sv =====
// ----------------------------------------------------------------------------
// wstd_chk: port-level checker for the dispatcher
// Watches handshakes and busy periods on the top level's ports.
// ----------------------------------------------------------------------------
module wstd_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input wstd_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input wstd_pkg::out_word_t out_data
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_stall))
    else $error("reset must clear the result and hold off input");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");

  a_task_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.cmd == wstd_pkg::CMD_TASK)) |=> in_stall)
    else $error("task word accepted without going busy");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.cmd == wstd_pkg::CMD_LOAD)) |=> !in_stall)
    else $error("load word must complete in one cycle");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without a task in progress");

endmodule

bind weighted_server_task_dispatcher_top wstd_chk u_wstd_chk (.*);
